// File: src/deq_pkg.sv
package deq_pkg;

  localparam int CAPACITY   = 256;
  localparam int DATA_WIDTH = 32;

  localparam int ADDR_W  = $clog2(CAPACITY);
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int IDX_W   = CNT_W + 1;
  localparam int POS_W   = 9;
  localparam int COUNT_W = 9;
  localparam int CMP_W   = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_READ_AT    = 3'd4,
    OP_INSERT_AT  = 3'd5,
    OP_ERASE_AT   = 3'd6,
    OP_CLEAR      = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_OOB   = 2'd3
  } status_t;

  typedef struct packed {
    op_t                opcode;
    logic [POS_W-1:0]   position;
    logic signed [31:0] value;
  } deq_in_t;

  typedef struct packed {
    logic signed [31:0] read_data;
    status_t            status;
    logic [COUNT_W-1:0] count;
  } deq_out_t;

  typedef struct packed {
    logic                  we;
    logic [ADDR_W-1:0]     waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic                  re;
    logic [ADDR_W-1:0]     raddr;
  } deq_mem_req_t;

  function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] h,
                                                input logic [IDX_W-1:0] idx);
    logic [IDX_W:0] s;
    s = (IDX_W+1)'(h) + (IDX_W+1)'(idx);
    if (s >= (IDX_W+1)'(CAPACITY)) begin
      s = s - (IDX_W+1)'(CAPACITY);
    end
    return ADDR_W'(s);
  endfunction

  function automatic logic [ADDR_W-1:0] slot_inc(input logic [ADDR_W-1:0] a);
    return (a == ADDR_W'(CAPACITY - 1)) ? '0 : ADDR_W'(a + 1'b1);
  endfunction

  function automatic logic [ADDR_W-1:0] slot_dec(input logic [ADDR_W-1:0] a);
    return (a == '0) ? ADDR_W'(CAPACITY - 1) : ADDR_W'(a - 1'b1);
  endfunction

  function automatic logic [DATA_WIDTH-1:0] store_of(input logic [31:0] v);
    return DATA_WIDTH'(v);
  endfunction

  function automatic logic signed [31:0] load_of(input logic [DATA_WIDTH-1:0] d);
    logic signed [DATA_WIDTH-1:0] s;
    s = d;
    return 32'(s);
  endfunction

endpackage

// File: src/double_ended_queue.sv
// Fixed-capacity double-ended queue held in one ring memory with a head slot
// and an element count. An item is one operation: push or pop at either end,
// read at an index, insert before an index, erase at an index, or clear.
// An item is taken on a rising edge where start is high and busy is low.
// Every item gives exactly one result on out_item, shown for one cycle with
// out_valid high; the receiver cannot stall, so results are never held.
// Push, pop, clear and refused items show their result in the cycle after
// acceptance with busy staying low, so one item can be taken every cycle.
// A read holds busy in the S_READ state while the memory returns the entry,
// and its result is registered from the returned entry in that state.
// Insert and erase move n entries toward the nearer end. On the front side n
// is the position; on the back side it is the count minus the position for
// an insert and one less than that for an erase.
// The memory gives one read and one write per cycle, so the moves run one
// per cycle, each entry written one slot over as the next is read; an insert
// then fills the freed slot. The next item may be taken in the result's cycle.
// Synchronous reset empties the queue and sets the head slot to zero; the
// memory itself is not cleared, since no entry is read before it is written.
module double_ended_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  deq_pkg::deq_in_t   in_item,
  output logic               out_valid,
  output deq_pkg::deq_out_t  out_item
);
  import deq_pkg::*;

  deq_mem_req_t          mem_req;
  logic [DATA_WIDTH-1:0] mem_rdata;

  deq_ram u_ram (
    .clk       (clk),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.count <= COUNT_W'(CAPACITY)))
    else $error("Result count exceeds capacity.");

  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_item.opcode == OP_CLEAR))
      |=> (out_valid && (out_item.count == '0) && (out_item.status == ST_OK)))
    else $error("Clear did not empty the queue in the next cycle.");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.status != ST_OK)) |-> (out_item.read_data == '0))
    else $error("Refused item returned nonzero data.");

  a_push_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && ((in_item.opcode == OP_PUSH_BACK) ||
                        (in_item.opcode == OP_PUSH_FRONT))) |=> (out_valid && !busy))
    else $error("Push result missing in the cycle after acceptance.");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_req.we && mem_req.re) |-> (mem_req.waddr != mem_req.raddr))
    else $error("Memory read and write hit the same entry in one cycle.");

endmodule

// File: src/deq_ram.sv
module deq_ram (
  input  logic                          clk,
  input  deq_pkg::deq_mem_req_t         mem_req,
  output logic [deq_pkg::DATA_WIDTH-1:0] mem_rdata
);
  import deq_pkg::*;

  logic [DATA_WIDTH-1:0] mem [CAPACITY];
  logic [DATA_WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.waddr] <= mem_req.wdata;
    end
    if (mem_req.re) begin
      rdata_r <= mem[mem_req.raddr];
    end
  end

  assign mem_rdata = rdata_r;

endmodule

// File: src/deq_ctrl.sv
module deq_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  deq_pkg::deq_in_t               in_item,
  output logic                           out_valid,
  output deq_pkg::deq_out_t              out_item,
  output deq_pkg::deq_mem_req_t          mem_req,
  input  logic [deq_pkg::DATA_WIDTH-1:0] mem_rdata
);
  import deq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SHIFT
  } state_t;

  state_t                state_r;
  logic [ADDR_W-1:0]     head_r;
  logic [CNT_W-1:0]      count_r;
  logic [ADDR_W-1:0]     src_r;
  logic [CNT_W-1:0]      n_r;
  logic                  up_r;
  logic                  ins_r;
  logic [ADDR_W-1:0]     fin_r;
  logic [DATA_WIDTH-1:0] val_r;
  logic                  pend_r;
  logic [ADDR_W-1:0]     pend_dst_r;
  logic                  out_valid_r;
  deq_out_t              out_item_r;

  logic              accept;
  logic [CMP_W-1:0]  p_w;
  logic [CMP_W-1:0]  c_w;
  logic              full;
  logic              empty;
  logic              front;
  status_t           st;
  logic [IDX_W-1:0]  pi;
  logic [IDX_W-1:0]  ci;
  logic [ADDR_W-1:0] h_dec;
  logic [ADDR_W-1:0] h_inc;
  logic [ADDR_W-1:0] sh_src;
  logic [CNT_W-1:0]  sh_n;
  logic [ADDR_W-1:0] sh_head;
  logic [ADDR_W-1:0] sh_fin;
  logic              sh_up;
  logic [CNT_W-1:0]  cnt_inc;
  logic [CNT_W-1:0]  cnt_dec;
  logic [CNT_W-1:0]  acc_cnt;
  logic              acc_done;

  always_comb begin
    accept  = start && (state_r == S_IDLE);
    p_w     = CMP_W'(in_item.position);
    c_w     = CMP_W'(count_r);
    pi      = IDX_W'(in_item.position);
    ci      = IDX_W'(count_r);
    full    = (count_r == CNT_W'(CAPACITY));
    empty   = (count_r == '0);
    front   = (({1'b0, p_w} << 1) < {1'b0, c_w});
    h_dec   = slot_dec(head_r);
    h_inc   = slot_inc(head_r);
    cnt_inc = CNT_W'(count_r + 1'b1);
    cnt_dec = CNT_W'(count_r - 1'b1);

    st = ST_OK;
    unique case (in_item.opcode)
      OP_PUSH_BACK, OP_PUSH_FRONT: if (full) st = ST_FULL;
      OP_POP_BACK, OP_POP_FRONT:   if (empty) st = ST_EMPTY;
      OP_READ_AT, OP_ERASE_AT:     if (p_w >= c_w) st = ST_OOB;
      OP_INSERT_AT: begin
        if (full) st = ST_FULL;
        else if (p_w > c_w) st = ST_OOB;
      end
      OP_CLEAR: st = ST_OK;
    endcase

    acc_cnt  = count_r;
    acc_done = 1'b1;
    if (st == ST_OK) begin
      unique case (in_item.opcode)
        OP_PUSH_BACK, OP_PUSH_FRONT:           acc_cnt = cnt_inc;
        OP_POP_BACK, OP_POP_FRONT:             acc_cnt = cnt_dec;
        OP_CLEAR:                              acc_cnt = '0;
        OP_READ_AT, OP_INSERT_AT, OP_ERASE_AT: acc_done = 1'b0;
      endcase
    end

    sh_fin = '0;
    if (in_item.opcode == OP_INSERT_AT) begin
      if (front) begin
        sh_head = h_dec;
        sh_src  = head_r;
        sh_n    = CNT_W'(pi);
        sh_up   = 1'b1;
        sh_fin  = slot_of(h_dec, pi);
      end else begin
        sh_head = head_r;
        sh_src  = slot_of(head_r, IDX_W'(ci - IDX_W'(1)));
        sh_n    = CNT_W'(ci - pi);
        sh_up   = 1'b0;
        sh_fin  = slot_of(head_r, pi);
      end
    end else begin
      if (front) begin
        sh_head = h_inc;
        sh_src  = slot_of(head_r, IDX_W'(pi - IDX_W'(1)));
        sh_n    = CNT_W'(pi);
        sh_up   = 1'b0;
      end else begin
        sh_head = head_r;
        sh_src  = slot_of(head_r, IDX_W'(pi + IDX_W'(1)));
        sh_n    = CNT_W'(ci - IDX_W'(1) - pi);
        sh_up   = 1'b1;
      end
    end

    mem_req = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept && (st == ST_OK)) begin
          if (in_item.opcode == OP_PUSH_BACK) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = slot_of(head_r, ci);
            mem_req.wdata = store_of(in_item.value);
          end else if (in_item.opcode == OP_PUSH_FRONT) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = h_dec;
            mem_req.wdata = store_of(in_item.value);
          end else if (in_item.opcode == OP_READ_AT) begin
            mem_req.re    = 1'b1;
            mem_req.raddr = slot_of(head_r, pi);
          end
        end
      end
      S_READ: begin
      end
      S_SHIFT: begin
        mem_req.re    = (n_r != '0);
        mem_req.raddr = src_r;
        if (pend_r) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = pend_dst_r;
          mem_req.wdata = mem_rdata;
        end else if ((n_r == '0) && ins_r) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = fin_r;
          mem_req.wdata = val_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            out_item_r.read_data <= '0;
            out_item_r.status    <= st;
            out_item_r.count     <= COUNT_W'(acc_cnt);
            out_valid_r          <= acc_done;
            if (st == ST_OK) begin
              unique case (in_item.opcode)
                OP_PUSH_BACK, OP_PUSH_FRONT: begin
                  if (in_item.opcode == OP_PUSH_FRONT) head_r <= h_dec;
                  count_r <= cnt_inc;
                end
                OP_POP_BACK, OP_POP_FRONT: begin
                  if (in_item.opcode == OP_POP_FRONT) head_r <= h_inc;
                  count_r <= cnt_dec;
                end
                OP_READ_AT: begin
                  state_r <= S_READ;
                end
                OP_INSERT_AT, OP_ERASE_AT: begin
                  head_r  <= sh_head;
                  src_r   <= sh_src;
                  n_r     <= sh_n;
                  up_r    <= sh_up;
                  fin_r   <= sh_fin;
                  ins_r   <= (in_item.opcode == OP_INSERT_AT);
                  val_r   <= store_of(in_item.value);
                  pend_r  <= 1'b0;
                  state_r <= S_SHIFT;
                end
                OP_CLEAR: begin
                  head_r  <= '0;
                  count_r <= '0;
                end
              endcase
            end
          end else begin
            out_valid_r <= 1'b0;
          end
        end
        S_READ: begin
          out_item_r.read_data <= load_of(mem_rdata);
          out_valid_r          <= 1'b1;
          state_r              <= S_IDLE;
        end
        S_SHIFT: begin
          if (n_r != '0) begin
            src_r       <= up_r ? slot_inc(src_r) : slot_dec(src_r);
            pend_dst_r  <= up_r ? slot_dec(src_r) : slot_inc(src_r);
            n_r         <= CNT_W'(n_r - 1'b1);
            pend_r      <= 1'b1;
            out_valid_r <= 1'b0;
          end else if (pend_r) begin
            pend_r      <= 1'b0;
            out_valid_r <= 1'b0;
          end else begin
            count_r          <= ins_r ? cnt_inc : cnt_dec;
            out_item_r.count <= COUNT_W'(ins_r ? cnt_inc : cnt_dec);
            out_valid_r      <= 1'b1;
            state_r          <= S_IDLE;
          end
        end
        default: begin
          out_valid_r <= 1'b0;
          state_r     <= S_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
